FILE: rtl/core/pidpi_pkg.sv
// Shared types and constants for the positional/incremental PID controller.
// Holds field widths, register indexes, reset values and the control struct.
// No dependencies; every other file of the block imports it.
package pidpi_pkg;

  // Field and datapath widths
  localparam int unsigned IN_W      = 16;
  localparam int unsigned ERR_W     = IN_W + 1;
  localparam int unsigned DERR_W    = ERR_W + 1;
  localparam int unsigned DDERR_W   = ERR_W + 2;
  localparam int unsigned GAIN_W    = 20;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned BND_W     = OUT_W + FRAC_W;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DIV_CNT_W = $clog2(BND_W);

  // Products: unsigned gain widened by one sign bit times a signed operand
  localparam int unsigned P_PROD_W = GAIN_W + 1 + DERR_W;
  localparam int unsigned I_PROD_W = GAIN_W + 1 + BND_W;
  localparam int unsigned D_PROD_W = GAIN_W + 1 + DDERR_W;
  localparam int unsigned P_TERM_W = P_PROD_W - FRAC_W;
  localparam int unsigned I_TERM_W = I_PROD_W - FRAC_W;
  localparam int unsigned D_TERM_W = D_PROD_W - FRAC_W;
  // Sum of last drive and three terms; integral term dominates
  localparam int unsigned RAW_W    = I_TERM_W + 2;

  // Register indexes on the write port
  localparam logic [IDX_W-1:0] REG_MODE  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_KP    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_KI    = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_KD    = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_UPPER = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_LOWER = IDX_W'(5);

  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } mode_e;

  // Reset values of the registers
  localparam int RstKpVal    = 51200;
  localparam int RstKiVal    = 5120;
  localparam int RstKdVal    = 0;
  localparam int RstUpperVal = 60000;
  localparam int RstLowerVal = -60000;

  localparam logic [GAIN_W-1:0]       RST_KP    = GAIN_W'(RstKpVal);
  localparam logic [GAIN_W-1:0]       RST_KI    = GAIN_W'(RstKiVal);
  localparam logic [GAIN_W-1:0]       RST_KD    = GAIN_W'(RstKdVal);
  localparam logic signed [OUT_W-1:0] RST_UPPER = OUT_W'(RstUpperVal);
  localparam logic signed [OUT_W-1:0] RST_LOWER = OUT_W'(RstLowerVal);

  // Integral bounds that match the reset limits and reset integral gain
  localparam logic signed [BND_W-1:0] RST_BND_HI =
    BND_W'(RstUpperVal * (2 ** FRAC_W) / RstKiVal);
  localparam logic signed [BND_W-1:0] RST_BND_LO =
    BND_W'(RstLowerVal * (2 ** FRAC_W) / RstKiVal);

  // Controller settings as held in the register file
  typedef struct packed {
    mode_e                    mode;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic [GAIN_W-1:0]        kd;
    logic signed [OUT_W-1:0]  upper;
    logic signed [OUT_W-1:0]  lower;
  } ctl_t;

  // Integral bound sequencer
  typedef enum logic [2:0] {
    BND_IDLE,
    BND_START_HI,
    BND_WAIT_HI,
    BND_START_LO,
    BND_WAIT_LO
  } bnd_state_e;

endpackage

FILE: rtl/core/pidpi_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero; used for the integral bounds.
// Depends on pidpi_pkg.
module pidpi_div import pidpi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [BND_W-1:0] dividend_i,
  input  logic [GAIN_W-1:0]       divisor_i,
  output logic                    done_o,
  output logic signed [BND_W-1:0] quotient_o
);

  logic [BND_W-1:0]     acc_q;
  logic [GAIN_W-1:0]    rem_q;
  logic [GAIN_W-1:0]    divisor_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 neg_q;
  logic                 done_q;

  logic [BND_W-1:0]  mag;
  logic [GAIN_W:0]   trial;
  logic              qbit;
  logic [GAIN_W-1:0] rem_d;

  // Magnitude of the dividend, divisor is never negative
  assign mag = dividend_i[BND_W-1] ? BND_W'(~dividend_i + 1'b1) : dividend_i;

  // Restoring step: bring down the next dividend bit and try to subtract
  always_comb begin
    trial = {rem_q, acc_q[BND_W-1]};
    qbit  = (trial >= {1'b0, divisor_q});
    if (qbit) begin
      rem_d = GAIN_W'(trial - {1'b0, divisor_q});
    end else begin
      rem_d = trial[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(BND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q     <= mag;
      rem_q     <= '0;
      divisor_q <= divisor_i;
      neg_q     <= dividend_i[BND_W-1];
    end else if (busy_q) begin
      acc_q <= {acc_q[BND_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? BND_W'(~acc_q + 1'b1) : acc_q;

endmodule

FILE: rtl/core/pidpi_bounds.sv
// Integral bound sequencer: divides both output limits by the integral gain.
// Runs the shared divider twice after a write to integral gain or limits.
// Depends on pidpi_pkg and pidpi_div.
module pidpi_bounds import pidpi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    recalc_i,
  input  ctl_t                    ctl_i,
  output logic                    busy_o,
  output logic signed [BND_W-1:0] bnd_hi_o,
  output logic signed [BND_W-1:0] bnd_lo_o
);

  bnd_state_e state_q, state_d;

  logic                    div_start;
  logic                    sel_lo;
  logic                    div_done;
  logic signed [BND_W-1:0] dividend;
  logic signed [BND_W-1:0] quotient;
  logic signed [BND_W-1:0] bnd_hi_q;
  logic signed [BND_W-1:0] bnd_lo_q;

  // Next state; a new write restarts the pair of divisions
  always_comb begin
    state_d = state_q;
    case (state_q)
      BND_IDLE:     state_d = BND_IDLE;
      BND_START_HI: state_d = BND_WAIT_HI;
      BND_WAIT_HI:  if (div_done) state_d = BND_START_LO;
      BND_START_LO: state_d = BND_WAIT_LO;
      BND_WAIT_LO:  if (div_done) state_d = BND_IDLE;
      default:      state_d = BND_IDLE;
    endcase
    if (recalc_i) begin
      state_d = BND_START_HI;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    div_start = 1'b0;
    sel_lo    = 1'b0;
    busy_o    = 1'b1;
    case (state_q)
      BND_IDLE:     busy_o = 1'b0;
      BND_START_HI: div_start = 1'b1;
      BND_WAIT_HI:  sel_lo = 1'b0;
      BND_START_LO: begin
        div_start = 1'b1;
        sel_lo    = 1'b1;
      end
      BND_WAIT_LO:  sel_lo = 1'b1;
      default:      busy_o = 1'b0;
    endcase
  end

  // Limit times 256 as the dividend
  assign dividend = sel_lo ? {ctl_i.lower, {FRAC_W{1'b0}}} : {ctl_i.upper, {FRAC_W{1'b0}}};

  pidpi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (ctl_i.ki),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BND_IDLE;
      bnd_hi_q <= RST_BND_HI;
      bnd_lo_q <= RST_BND_LO;
    end else begin
      state_q <= state_d;
      if (div_done && state_q == BND_WAIT_HI) begin
        bnd_hi_q <= quotient;
      end
      if (div_done && state_q == BND_WAIT_LO) begin
        bnd_lo_q <= quotient;
      end
    end
  end

  assign bnd_hi_o = bnd_hi_q;
  assign bnd_lo_o = bnd_lo_q;

endmodule

FILE: rtl/core/pidpi_front.sv
// Front stage: input register, error history, error sum and the three gain
// products, registered as shifted terms. Depends on pidpi_pkg.
module pidpi_front import pidpi_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic                       step_i,
  input  logic signed [IN_W-1:0]     setpoint_i,
  input  logic signed [IN_W-1:0]     measurement_i,
  input  ctl_t                       ctl_i,
  input  logic signed [BND_W-1:0]    bnd_hi_i,
  input  logic signed [BND_W-1:0]    bnd_lo_i,
  output logic signed [P_TERM_W-1:0] p_term_o,
  output logic signed [I_TERM_W-1:0] i_term_o,
  output logic signed [D_TERM_W-1:0] d_term_o
);

  logic signed [IN_W-1:0]     setpoint_q;
  logic signed [IN_W-1:0]     measurement_q;
  logic signed [ERR_W-1:0]    prev_error_q;
  logic signed [ERR_W-1:0]    prev_prev_error_q;
  logic signed [SUM_W-1:0]    error_sum_q;
  logic signed [P_TERM_W-1:0] p_term_q;
  logic signed [I_TERM_W-1:0] i_term_q;
  logic signed [D_TERM_W-1:0] d_term_q;

  logic signed [ERR_W-1:0]    err;
  logic signed [DERR_W-1:0]   derr;
  logic signed [DDERR_W-1:0]  dderr;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_next;
  logic signed [DERR_W-1:0]   p_op;
  logic signed [BND_W-1:0]    i_op;
  logic signed [DDERR_W-1:0]  d_op;
  logic signed [GAIN_W:0]     kp_s;
  logic signed [GAIN_W:0]     ki_s;
  logic signed [GAIN_W:0]     kd_s;
  logic signed [P_PROD_W-1:0] p_prod;
  logic signed [I_PROD_W-1:0] i_prod;
  logic signed [D_PROD_W-1:0] d_prod;

  // Input register, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      setpoint_q    <= setpoint_i;
      measurement_q <= measurement_i;
    end
  end

  // Error and its first and second differences
  assign err   = ERR_W'(setpoint_q) - ERR_W'(measurement_q);
  assign derr  = DERR_W'(err) - DERR_W'(prev_error_q);
  assign dderr = DDERR_W'(err) - (DDERR_W'(prev_error_q) <<< 1)
               + DDERR_W'(prev_prev_error_q);

  // Saturating error sum, then integral clamp if ki is nonzero (lower bound applied last)
  always_comb begin
    sum_wide = (SUM_W + 1)'(error_sum_q) + (SUM_W + 1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                 : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_W-1:0];
    end
    if (ctl_i.ki != '0) begin
      if (sum_next > SUM_W'(bnd_hi_i)) sum_next = SUM_W'(bnd_hi_i);
      if (sum_next < SUM_W'(bnd_lo_i)) sum_next = SUM_W'(bnd_lo_i);
    end
  end

  // Operand selection per form; a clamped sum always fits the bound width,
  // and with zero integral gain the integral product is zero anyway
  always_comb begin
    if (ctl_i.mode == MODE_POSITIONAL) begin
      p_op = DERR_W'(err);
      i_op = sum_next[BND_W-1:0];
      d_op = DDERR_W'(derr);
    end else begin
      p_op = derr;
      i_op = BND_W'(err);
      d_op = dderr;
    end
  end

  assign kp_s = {1'b0, ctl_i.kp};
  assign ki_s = {1'b0, ctl_i.ki};
  assign kd_s = {1'b0, ctl_i.kd};

  assign p_prod = kp_s * p_op;
  assign i_prod = ki_s * i_op;
  assign d_prod = kd_s * d_op;

  // Controller state, advanced once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_error_q      <= '0;
      prev_prev_error_q <= '0;
      error_sum_q       <= '0;
    end else if (step_i) begin
      prev_error_q <= err;
      if (ctl_i.mode == MODE_POSITIONAL) begin
        error_sum_q <= sum_next;
      end else begin
        prev_prev_error_q <= prev_error_q;
      end
    end
  end

  // Term register; dropping the fraction bits is a floor shift
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      p_term_q <= p_prod[P_PROD_W-1:FRAC_W];
      i_term_q <= i_prod[I_PROD_W-1:FRAC_W];
      d_term_q <= d_prod[D_PROD_W-1:FRAC_W];
    end
  end

  assign p_term_o = p_term_q;
  assign i_term_o = i_term_q;
  assign d_term_o = d_term_q;

endmodule

FILE: rtl/core/pidpi_back.sv
// Back stage: sums the terms (plus last drive in incremental form), clamps
// to the output limits and holds the result. Depends on pidpi_pkg.
module pidpi_back import pidpi_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  ctl_t                       ctl_i,
  input  logic signed [P_TERM_W-1:0] p_term_i,
  input  logic signed [I_TERM_W-1:0] i_term_i,
  input  logic signed [D_TERM_W-1:0] d_term_i,
  output logic signed [OUT_W-1:0]    drive_o
);

  // The result register doubles as the last drive value
  logic signed [OUT_W-1:0] drive_q;
  logic signed [RAW_W-1:0] base;
  logic signed [RAW_W-1:0] raw;
  logic signed [RAW_W-1:0] clamped;

  assign base = (ctl_i.mode == MODE_INCREMENTAL) ? RAW_W'(drive_q) : '0;
  assign raw  = base + RAW_W'(p_term_i) + RAW_W'(i_term_i) + RAW_W'(d_term_i);

  // Lower limit first, upper limit wins when the two cross
  always_comb begin
    clamped = raw;
    if (clamped < RAW_W'(ctl_i.lower)) clamped = RAW_W'(ctl_i.lower);
    if (clamped > RAW_W'(ctl_i.upper)) clamped = RAW_W'(ctl_i.upper);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= '0;
    end else if (step_i) begin
      drive_q <= clamped[OUT_W-1:0];
    end
  end

  assign drive_o = drive_q;

endmodule

FILE: rtl/core/pid_position_or_increment.sv
// PID controller, positional or incremental form; top level.
// An input transfer passes the input, term and result registers in order before
// the result is valid; one item per cycle sustained, stalls follow out_ready. A
// write to integral gain or either limit runs the bit-serial divider twice,
// holding in_ready low for the write cycle and until both divisions finish.
// Async active-low reset loads the register defaults and matching integral
// bounds and clears all history.
module pid_position_or_increment import pidpi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [OUT_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  setpoint_i,
  input  logic signed [IN_W-1:0]  measurement_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] drive_o
);

  ctl_t ctl_q;

  logic in_reg_valid_q;
  logic term_valid_q;
  logic out_valid_q;
  logic adv;
  logic in_fire;
  logic recalc;
  logic bnd_busy;

  logic signed [BND_W-1:0]    bnd_hi;
  logic signed [BND_W-1:0]    bnd_lo;
  logic signed [P_TERM_W-1:0] p_term;
  logic signed [I_TERM_W-1:0] i_term;
  logic signed [D_TERM_W-1:0] d_term;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.mode  <= MODE_INCREMENTAL;
      ctl_q.kp    <= RST_KP;
      ctl_q.ki    <= RST_KI;
      ctl_q.kd    <= RST_KD;
      ctl_q.upper <= RST_UPPER;
      ctl_q.lower <= RST_LOWER;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:  ctl_q.mode  <= mode_e'(cfg_wdata_i[0]);
        REG_KP:    ctl_q.kp    <= cfg_wdata_i[GAIN_W-1:0];
        REG_KI:    ctl_q.ki    <= cfg_wdata_i[GAIN_W-1:0];
        REG_KD:    ctl_q.kd    <= cfg_wdata_i[GAIN_W-1:0];
        REG_UPPER: ctl_q.upper <= cfg_wdata_i;
        REG_LOWER: ctl_q.lower <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // Bounds depend on integral gain and both limits
  assign recalc = cfg_we_i && (cfg_idx_i == REG_KI || cfg_idx_i == REG_UPPER ||
                               cfg_idx_i == REG_LOWER);

  pidpi_bounds u_bounds (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .recalc_i (recalc),
    .ctl_i    (ctl_q),
    .busy_o   (bnd_busy),
    .bnd_hi_o (bnd_hi),
    .bnd_lo_o (bnd_lo)
  );

  // Pipeline moves as a whole whenever the result register can take data
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !bnd_busy && !cfg_we_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_reg_valid_q <= 1'b0;
      term_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else if (adv) begin
      in_reg_valid_q <= in_fire;
      term_valid_q   <= in_reg_valid_q;
      out_valid_q    <= term_valid_q;
    end
  end

  pidpi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_fire),
    .step_i        (adv && in_reg_valid_q),
    .setpoint_i    (setpoint_i),
    .measurement_i (measurement_i),
    .ctl_i         (ctl_q),
    .bnd_hi_i      (bnd_hi),
    .bnd_lo_i      (bnd_lo),
    .p_term_o      (p_term),
    .i_term_o      (i_term),
    .d_term_o      (d_term)
  );

  pidpi_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv && term_valid_q),
    .ctl_i    (ctl_q),
    .p_term_i (p_term),
    .i_term_i (i_term),
    .d_term_i (d_term),
    .drive_o  (drive_o)
  );

  assign out_valid_o = out_valid_q;

endmodule
